FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the given reset is high.
`define CDC_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while the given reset is high.
`define CDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cdconv_pkg.sv
// Field layout, calendar constants, reciprocal multipliers and tables of the converter.
`timescale 1ns / 1ps

package cdconv_pkg;

  typedef enum logic {
    ACT_FROM_CIVIL = 1'b0,
    ACT_FROM_COUNT = 1'b1
  } action_t;

  // Field widths.
  localparam int DC_W    = 26;
  localparam int SOD_W   = 17;
  localparam int YR_IN_W = 17;
  localparam int YR_W    = 18;
  localparam int MO_W    = 4;
  localparam int DY_W    = 5;
  localparam int WD_W    = 3;
  localparam int HR_W    = 5;
  localparam int MI_W    = 6;
  localparam int SC_W    = 6;

  // Slave tdata layout, lowest field first.
  localparam int IN_DC_LSB  = 0;
  localparam int IN_SOD_LSB = IN_DC_LSB + DC_W;
  localparam int IN_YR_LSB  = IN_SOD_LSB + SOD_W;
  localparam int IN_MO_LSB  = IN_YR_LSB + YR_IN_W;
  localparam int IN_DY_LSB  = IN_MO_LSB + MO_W;
  localparam int IN_HR_LSB  = IN_DY_LSB + DY_W;
  localparam int IN_MI_LSB  = IN_HR_LSB + HR_W;
  localparam int IN_SC_LSB  = IN_MI_LSB + MI_W;
  localparam int IN_END     = IN_SC_LSB + SC_W;
  localparam int S_TDATA_W  = ((IN_END + 7) / 8) * 8;

  // Master tdata layout, lowest field first.
  localparam int OUT_DC_LSB  = 0;
  localparam int OUT_SOD_LSB = OUT_DC_LSB + DC_W;
  localparam int OUT_YR_LSB  = OUT_SOD_LSB + SOD_W;
  localparam int OUT_MO_LSB  = OUT_YR_LSB + YR_W;
  localparam int OUT_DY_LSB  = OUT_MO_LSB + MO_W;
  localparam int OUT_WD_LSB  = OUT_DY_LSB + DY_W;
  localparam int OUT_HR_LSB  = OUT_WD_LSB + WD_W;
  localparam int OUT_MI_LSB  = OUT_HR_LSB + HR_W;
  localparam int OUT_SC_LSB  = OUT_MI_LSB + MI_W;
  localparam int OUT_END     = OUT_SC_LSB + SC_W;
  localparam int M_TDATA_W   = ((OUT_END + 7) / 8) * 8;

  // Calendar constants.
  localparam int DAYS_PER_ERA  = 146097;
  localparam int LAST_ERA_DAY  = 146096;
  localparam int CENT_DAYS     = 36524;
  localparam int QUAD_DAYS     = 1460;
  localparam int DAYS_PER_YEAR = 365;
  localparam int YEARS_PER_ERA = 400;
  localparam int DAYS_TO_EPOCH = 719468;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // Whole eras added so that the floor divisions work on non-negative values.
  localparam int YEAR_ERA_BIAS = 165;
  localparam int DAY_ERA_BIAS  = 230;
  localparam int YEAR_BIAS     = YEAR_ERA_BIAS * YEARS_PER_ERA;
  localparam int CIV_DAY_BIAS  = YEAR_ERA_BIAS * DAYS_PER_ERA + DAYS_TO_EPOCH;
  localparam int ZB_BIAS       = DAY_ERA_BIAS * DAYS_PER_ERA + DAYS_TO_EPOCH;
  localparam int ERA_YEAR_BIAS = DAY_ERA_BIAS * YEARS_PER_ERA;

  // Reciprocals m = ceil(2^s / d) with s = N + ceil(log2 d): exact floor(x / d) for x < 2^N.
  localparam int ERA_Y_SHIFT = 27;
  localparam logic [18:0] ERA_Y_MUL = 19'(((64'd1 << ERA_Y_SHIFT) + 64'(YEARS_PER_ERA)
                                          - 64'd1) / 64'(YEARS_PER_ERA));
  localparam int ERA_D_SHIFT = 45;
  localparam logic [27:0] ERA_D_MUL = 28'(((64'd1 << ERA_D_SHIFT) + 64'(DAYS_PER_ERA)
                                          - 64'd1) / 64'(DAYS_PER_ERA));
  localparam int HOUR_SHIFT = 29;
  localparam logic [17:0] HOUR_MUL = 18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR)
                                         - 64'd1) / 64'(SECS_PER_HOUR));
  localparam int MIN_SHIFT = 18;
  localparam logic [12:0] MIN_MUL = 13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN)
                                        - 64'd1) / 64'(SECS_PER_MIN));
  localparam int QUAD_SHIFT = 29;
  localparam logic [18:0] QUAD_MUL = 19'(((64'd1 << QUAD_SHIFT) + 64'(QUAD_DAYS)
                                         - 64'd1) / 64'(QUAD_DAYS));
  localparam int YEAR_SHIFT = 27;
  localparam logic [18:0] YEAR_MUL = 19'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_PER_YEAR)
                                         - 64'd1) / 64'(DAYS_PER_YEAR));

  // First day of each month within a March-based year: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    case (mp)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      4'd12:   return 9'd367;
      default: return 9'd0;
    endcase
  endfunction

  // Whole centuries in a year of era (0 to 399).
  function automatic logic [1:0] century_of(input logic [8:0] yoe);
    return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  endfunction

endpackage

FILE: src/civil_date_day_count_converter.sv
// Civil date and day count converter, an eleven-register pipeline.
// Each item passes stage registers p0 to p9 and then m_tdata, where m_tvalid offers it.
// Throughput: one transfer per cycle unless all stages are full and m_tready is low.
// A stage holds its item only while the next is full; empty stages fill as the output waits.
// Depth is set by the chain of reciprocal multiplies (year era, day era, year of era).
// Reset: rst (synchronous, active high) clears the stage valid flags; data is not reset.
`timescale 1ns / 1ps

module civil_date_day_count_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // in_day_count, in_second_of_day, in_year, in_month, in_day, in_hour, in_minute, in_second
  input  logic [cdconv_pkg::S_TDATA_W-1:0] s_tdata,
  // action
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_day_count, out_second_of_day, out_year, out_month, out_day, out_weekday,
  // out_hour, out_minute, out_second
  output logic [cdconv_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int NSTAGE = 11;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  // A stage loads when it is empty or the stage after it loads in the same cycle.
  assign adv[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
  for (genvar g = 0; g < NSTAGE - 1; g++) begin : g_ready
    assign adv[g] = !vld[g] || adv[g+1];
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage registers.
  cdconv_pkg::action_t p0_act, p1_act, p2_act, p3_act;
  logic [25:0] p0_dc, p1_dc, p2_dc, p3_dc;
  logic [16:0] p0_sod;
  logic [16:0] p0_yr;
  logic [3:0]  p0_mo;
  logic [4:0]  p0_dy;
  logic [4:0]  p0_hr;
  logic [5:0]  p0_mi;
  logic [5:0]  p0_sc;

  logic [17:0] p1_yb;
  logic [8:0]  p1_qy;
  logic [9:0]  p1_doy;
  logic [16:0] p1_sod, p2_sod, p3_sod, p4_sod, p5_sod, p6_sod, p7_sod, p8_sod, p9_sod;

  logic [26:0] p2_era, p3_era;
  logic [8:0]  p2_yoe;
  logic [9:0]  p2_doy;
  logic        p2_carry, p3_carry;
  logic [18:0] p3_doe;

  logic [25:0] p4_days, p5_days, p6_days, p7_days, p8_days, p9_days;
  logic [26:0] p5_zb;
  logic [8:0]  p5_qz, p6_qz, p7_qz, p8_qz, p9_qz;
  logic [4:0]  p5_hour, p6_hour, p7_hour, p8_hour, p9_hour;
  logic [5:0]  p5_oct;
  logic [17:0] p6_doe, p7_doe, p8_doe;
  logic [2:0]  p6_wd, p7_wd, p8_wd, p9_wd;
  logic [11:0] p6_rem, p7_rem;
  logic [5:0]  p7_min, p8_min, p9_min;
  logic [17:0] p7_nyr;
  logic [5:0]  p8_sec, p9_sec;
  logic [8:0]  p8_yoe, p9_yoe;
  logic [8:0]  p9_doy;

  // Stage 1: shift to a March-based year, era of the year, day of year, seconds of day.
  logic        early;
  logic [17:0] yr_adj;
  logic [17:0] yb;
  logic [36:0] yb_prod;
  logic [3:0]  mp_in;
  logic [9:0]  doy_civ;
  logic [16:0] sod_civ;
  logic [16:0] sod_raw;

  always_comb begin
    early   = (p0_mo <= 4'd2);
    yr_adj  = {p0_yr[16], p0_yr} - {17'd0, early};
    yb      = yr_adj + 18'(cdconv_pkg::YEAR_BIAS);
    yb_prod = 37'(yb) * 37'(cdconv_pkg::ERA_Y_MUL);
    mp_in   = early ? p0_mo + 4'd9 : p0_mo - 4'd3;
    doy_civ = 10'(cdconv_pkg::month_offset(mp_in)) + 10'(p0_dy) - 10'd1;
    sod_civ = 17'(p0_hr) * 17'(cdconv_pkg::SECS_PER_HOUR)
            + 17'(p0_mi) * 17'(cdconv_pkg::SECS_PER_MIN) + 17'(p0_sc);
    sod_raw = (p0_act == cdconv_pkg::ACT_FROM_COUNT) ? p0_sod : sod_civ;
  end

  // Stage 2: year of era, era in days, carry of whole days out of the seconds.
  logic [8:0]  yoe_civ;
  logic [26:0] era_prod;
  logic        carry;
  logic [16:0] sod_norm;

  always_comb begin
    yoe_civ  = 9'(p1_yb - 18'(p1_qy) * 18'(cdconv_pkg::YEARS_PER_ERA));
    era_prod = 27'(p1_qy) * 27'(cdconv_pkg::DAYS_PER_ERA);
    carry    = (p1_sod >= 17'(cdconv_pkg::SECS_PER_DAY));
    sod_norm = carry ? p1_sod - 17'(cdconv_pkg::SECS_PER_DAY) : p1_sod;
  end

  // Stage 3: day of era from the civil fields (may be -1 for day zero of March).
  logic [18:0] doe_civ;

  always_comb begin
    doe_civ = 19'(p2_yoe) * 19'(cdconv_pkg::DAYS_PER_YEAR) + 19'(p2_yoe[8:2])
            - 19'(cdconv_pkg::century_of(p2_yoe)) + {{9{p2_doy[9]}}, p2_doy};
  end

  // Stage 4: final day count, wrapped to its field width.
  logic [25:0] days_civ;
  logic [25:0] days_base;
  logic [25:0] days_sum;

  always_comb begin
    days_civ  = 26'(p3_era) + {{7{p3_doe[18]}}, p3_doe} - 26'(cdconv_pkg::CIV_DAY_BIAS);
    days_base = (p3_act == cdconv_pkg::ACT_FROM_COUNT) ? p3_dc : days_civ;
    days_sum  = days_base + 26'(p3_carry);
  end

  // Stage 5: era of the day count, hour, octal digit sum for the weekday.
  logic [26:0] zb;
  logic [54:0] zb_prod;
  logic [34:0] hr_prod;
  logic [26:0] days_ext;
  logic [5:0]  oct_sum;

  always_comb begin
    zb       = {p4_days[25], p4_days} + 27'(cdconv_pkg::ZB_BIAS);
    zb_prod  = 55'(zb) * 55'(cdconv_pkg::ERA_D_MUL);
    hr_prod  = 35'(p4_sod) * 35'(cdconv_pkg::HOUR_MUL);
    days_ext = {1'b0, p4_days};
    oct_sum  = '0;
    // Eight is one modulo seven, so the octal digits sum to the same residue.
    for (int k = 0; k < 9; k++) begin
      oct_sum = oct_sum + 6'(days_ext[3*k +: 3]);
    end
  end

  // Stage 6: day of era, seconds left in the hour, weekday.
  logic [17:0] doe;
  logic [11:0] rem_h;
  logic [3:0]  oct2;
  logic [3:0]  m7a;
  logic [2:0]  um7;
  logic [2:0]  weekday;

  always_comb begin
    doe   = 18'(p5_zb - 27'(p5_qz) * 27'(cdconv_pkg::DAYS_PER_ERA));
    rem_h = 12'(p5_sod - 17'(p5_hour) * 17'(cdconv_pkg::SECS_PER_HOUR));
    oct2  = 4'(p5_oct[5:3]) + 4'(p5_oct[2:0]);
    m7a   = (oct2 >= 4'd7) ? oct2 - 4'd7 : oct2;
    um7   = (m7a == 4'd7) ? 3'd0 : m7a[2:0];
    // A negative count is 2^26 below its bit pattern, and 2^26 leaves four modulo seven,
    // which cancels the epoch offset of four (1970-01-01 was a Thursday).
    if (p5_days[25]) begin
      weekday = um7;
    end else begin
      weekday = (um7 >= 3'd3) ? um7 - 3'd3 : um7 + 3'd4;
    end
  end

  // Stage 7: day of era with leap days removed, minute.
  logic [36:0] quad_prod;
  logic [6:0]  quads;
  logic [2:0]  cents;
  logic [17:0] nyr;
  logic [24:0] min_prod;

  always_comb begin
    quad_prod = 37'(p6_doe) * 37'(cdconv_pkg::QUAD_MUL);
    quads     = quad_prod[cdconv_pkg::QUAD_SHIFT +: 7];
    cents     = 3'(p6_doe >= 18'(cdconv_pkg::CENT_DAYS))
              + 3'(p6_doe >= 18'(2 * cdconv_pkg::CENT_DAYS))
              + 3'(p6_doe >= 18'(3 * cdconv_pkg::CENT_DAYS))
              + 3'(p6_doe >= 18'(cdconv_pkg::LAST_ERA_DAY));
    nyr       = p6_doe - 18'(quads) + 18'(cents)
              - 18'(p6_doe == 18'(cdconv_pkg::LAST_ERA_DAY));
    min_prod  = 25'(p6_rem) * 25'(cdconv_pkg::MIN_MUL);
  end

  // Stage 8: year of era, second.
  logic [36:0] yr_prod;
  logic [5:0]  sec;

  always_comb begin
    yr_prod = 37'(p7_nyr) * 37'(cdconv_pkg::YEAR_MUL);
    sec     = 6'(p7_rem - 12'(p7_min) * 12'(cdconv_pkg::SECS_PER_MIN));
  end

  // Stage 9: day of the March-based year.
  logic [8:0] doy;

  always_comb begin
    doy = 9'(p8_doe - (18'(p8_yoe) * 18'(cdconv_pkg::DAYS_PER_YEAR) + 18'(p8_yoe[8:2])
                       - 18'(cdconv_pkg::century_of(p8_yoe))));
  end

  // Stage 10: month, day and year, packed into the output register.
  logic [3:0]  mp_out;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [17:0] year_out;
  logic [cdconv_pkg::M_TDATA_W-1:0] m_tdata_next;

  always_comb begin
    mp_out = '0;
    for (int k = 1; k < 12; k++) begin
      mp_out = mp_out + 4'(p9_doy >= cdconv_pkg::month_offset(4'(k)));
    end
    day_out   = 5'(p9_doy - cdconv_pkg::month_offset(mp_out) + 9'd1);
    month_out = (mp_out < 4'd10) ? mp_out + 4'd3 : mp_out - 4'd9;
    year_out  = 18'(20'(p9_qz) * 20'(cdconv_pkg::YEARS_PER_ERA) + 20'(p9_yoe)
                    - 20'(cdconv_pkg::ERA_YEAR_BIAS) + 20'(mp_out >= 4'd10));

    m_tdata_next = '0;
    m_tdata_next[cdconv_pkg::OUT_DC_LSB  +: cdconv_pkg::DC_W]  = p9_days;
    m_tdata_next[cdconv_pkg::OUT_SOD_LSB +: cdconv_pkg::SOD_W] = p9_sod;
    m_tdata_next[cdconv_pkg::OUT_YR_LSB  +: cdconv_pkg::YR_W]  = year_out;
    m_tdata_next[cdconv_pkg::OUT_MO_LSB  +: cdconv_pkg::MO_W]  = month_out;
    m_tdata_next[cdconv_pkg::OUT_DY_LSB  +: cdconv_pkg::DY_W]  = day_out;
    m_tdata_next[cdconv_pkg::OUT_WD_LSB  +: cdconv_pkg::WD_W]  = p9_wd;
    m_tdata_next[cdconv_pkg::OUT_HR_LSB  +: cdconv_pkg::HR_W]  = p9_hour;
    m_tdata_next[cdconv_pkg::OUT_MI_LSB  +: cdconv_pkg::MI_W]  = p9_min;
    m_tdata_next[cdconv_pkg::OUT_SC_LSB  +: cdconv_pkg::SC_W]  = p9_sec;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_act <= cdconv_pkg::action_t'(s_tuser);
      p0_dc  <= s_tdata[cdconv_pkg::IN_DC_LSB  +: cdconv_pkg::DC_W];
      p0_sod <= s_tdata[cdconv_pkg::IN_SOD_LSB +: cdconv_pkg::SOD_W];
      p0_yr  <= s_tdata[cdconv_pkg::IN_YR_LSB  +: cdconv_pkg::YR_IN_W];
      p0_mo  <= s_tdata[cdconv_pkg::IN_MO_LSB  +: cdconv_pkg::MO_W];
      p0_dy  <= s_tdata[cdconv_pkg::IN_DY_LSB  +: cdconv_pkg::DY_W];
      p0_hr  <= s_tdata[cdconv_pkg::IN_HR_LSB  +: cdconv_pkg::HR_W];
      p0_mi  <= s_tdata[cdconv_pkg::IN_MI_LSB  +: cdconv_pkg::MI_W];
      p0_sc  <= s_tdata[cdconv_pkg::IN_SC_LSB  +: cdconv_pkg::SC_W];
    end
    if (adv[1]) begin
      p1_act <= p0_act;
      p1_dc  <= p0_dc;
      p1_yb  <= yb;
      p1_qy  <= yb_prod[cdconv_pkg::ERA_Y_SHIFT +: 9];
      p1_doy <= doy_civ;
      p1_sod <= sod_raw;
    end
    if (adv[2]) begin
      p2_act   <= p1_act;
      p2_dc    <= p1_dc;
      p2_era   <= era_prod;
      p2_yoe   <= yoe_civ;
      p2_doy   <= p1_doy;
      p2_sod   <= sod_norm;
      p2_carry <= carry;
    end
    if (adv[3]) begin
      p3_act   <= p2_act;
      p3_dc    <= p2_dc;
      p3_era   <= p2_era;
      p3_doe   <= doe_civ;
      p3_sod   <= p2_sod;
      p3_carry <= p2_carry;
    end
    if (adv[4]) begin
      p4_days <= days_sum;
      p4_sod  <= p3_sod;
    end
    if (adv[5]) begin
      p5_days <= p4_days;
      p5_sod  <= p4_sod;
      p5_zb   <= zb;
      p5_qz   <= zb_prod[cdconv_pkg::ERA_D_SHIFT +: 9];
      p5_hour <= hr_prod[cdconv_pkg::HOUR_SHIFT +: 5];
      p5_oct  <= oct_sum;
    end
    if (adv[6]) begin
      p6_days <= p5_days;
      p6_sod  <= p5_sod;
      p6_doe  <= doe;
      p6_qz   <= p5_qz;
      p6_wd   <= weekday;
      p6_hour <= p5_hour;
      p6_rem  <= rem_h;
    end
    if (adv[7]) begin
      p7_days <= p6_days;
      p7_sod  <= p6_sod;
      p7_doe  <= p6_doe;
      p7_qz   <= p6_qz;
      p7_wd   <= p6_wd;
      p7_hour <= p6_hour;
      p7_rem  <= p6_rem;
      p7_min  <= min_prod[cdconv_pkg::MIN_SHIFT +: 6];
      p7_nyr  <= nyr;
    end
    if (adv[8]) begin
      p8_days <= p7_days;
      p8_sod  <= p7_sod;
      p8_doe  <= p7_doe;
      p8_qz   <= p7_qz;
      p8_wd   <= p7_wd;
      p8_hour <= p7_hour;
      p8_min  <= p7_min;
      p8_sec  <= sec;
      p8_yoe  <= yr_prod[cdconv_pkg::YEAR_SHIFT +: 9];
    end
    if (adv[9]) begin
      p9_days <= p8_days;
      p9_sod  <= p8_sod;
      p9_qz   <= p8_qz;
      p9_wd   <= p8_wd;
      p9_hour <= p8_hour;
      p9_min  <= p8_min;
      p9_sec  <= p8_sec;
      p9_yoe  <= p8_yoe;
      p9_doy  <= doy;
    end
    if (adv[10]) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

FILE: src/cdconv_check.sv
// Port-level checker for the civil date converter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdconv_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cdconv_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [16:0] sod;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [16:0] sod_sum;
  logic        in_busy;

  assign sod     = m_tdata[cdconv_pkg::OUT_SOD_LSB +: cdconv_pkg::SOD_W];
  assign month   = m_tdata[cdconv_pkg::OUT_MO_LSB  +: cdconv_pkg::MO_W];
  assign day     = m_tdata[cdconv_pkg::OUT_DY_LSB  +: cdconv_pkg::DY_W];
  assign weekday = m_tdata[cdconv_pkg::OUT_WD_LSB  +: cdconv_pkg::WD_W];
  assign hour    = m_tdata[cdconv_pkg::OUT_HR_LSB  +: cdconv_pkg::HR_W];
  assign minute  = m_tdata[cdconv_pkg::OUT_MI_LSB  +: cdconv_pkg::MI_W];
  assign second  = m_tdata[cdconv_pkg::OUT_SC_LSB  +: cdconv_pkg::SC_W];
  assign sod_sum = 17'(hour) * 17'(cdconv_pkg::SECS_PER_HOUR)
                 + 17'(minute) * 17'(cdconv_pkg::SECS_PER_MIN) + 17'(second);
  assign in_busy = s_tvalid && !s_tready;

  `CDC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CDC_ASSERT(a_time_split, clk, rst, m_tvalid, sod == sod_sum, "hour, minute and second do not match the second of day")
  `CDC_ASSERT(a_date_range, clk, rst, m_tvalid, (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0) && (weekday <= 3'd6), "month, day or weekday out of range")
  `CDC_ASSERT(a_no_back_stall, clk, rst, m_tready, !in_busy, "input stalled while the output drains")
  `CDC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result offered right after reset")

endmodule

bind civil_date_day_count_converter cdconv_check u_cdconv_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/testbench.sv
// Self-checking stream testbench for the civil date and day count converter.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_ITEMS = 540;
  localparam int BLOCK_ITEMS  = 50;

  typedef struct packed {
    cdconv_pkg::action_t                         act;
    logic signed [cdconv_pkg::DC_W-1:0]          day_count;
    logic        [cdconv_pkg::SOD_W-1:0]         second_of_day;
    logic signed [cdconv_pkg::YR_IN_W-1:0]       year;
    logic        [cdconv_pkg::MO_W-1:0]          month;
    logic        [cdconv_pkg::DY_W-1:0]          day;
    logic        [cdconv_pkg::HR_W-1:0]          hour;
    logic        [cdconv_pkg::MI_W-1:0]          minute;
    logic        [cdconv_pkg::SC_W-1:0]          second;
  } timestamp_t;

  typedef struct packed {
    logic signed [cdconv_pkg::DC_W-1:0]  day_count;
    logic        [cdconv_pkg::SOD_W-1:0] second_of_day;
    logic signed [cdconv_pkg::YR_W-1:0]  year;
    logic        [cdconv_pkg::MO_W-1:0]  month;
    logic        [cdconv_pkg::DY_W-1:0]  day;
    logic        [cdconv_pkg::WD_W-1:0]  weekday;
    logic        [cdconv_pkg::HR_W-1:0]  hour;
    logic        [cdconv_pkg::MI_W-1:0]  minute;
    logic        [cdconv_pkg::SC_W-1:0]  second;
  } civil_time_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cdconv_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [cdconv_pkg::M_TDATA_W-1:0] m_tdata;

  civil_time_t expected_times[$];
  int          failures = 0;
  int          cycle_count = 0;
  int          hold_off = 0;
  bit          steady_source = 1'b0;
  bit          steady_sink = 1'b0;
  civil_time_t got, want;
  string       diff;

  civil_date_day_count_converter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Converts one timestamp to its day count, time of day and civil date.
  function automatic civil_time_t civil_convert(input timestamp_t ts);
    longint days, sod, y, m, d, era, yoe, mp, doy, doe, z, wd;
    logic signed [cdconv_pkg::DC_W-1:0] wrapped;
    civil_time_t res;
    if (ts.act == cdconv_pkg::ACT_FROM_COUNT) begin
      days = longint'(ts.day_count);
      sod  = longint'(ts.second_of_day);
    end else begin
      y = longint'(ts.year);
      m = longint'(ts.month);
      d = longint'(ts.day);
      // The year starts in March, so January and February belong to the year before.
      if (m <= 2) y = y - 1;
      era  = (y >= 0 ? y : y - (cdconv_pkg::YEARS_PER_ERA - 1)) / cdconv_pkg::YEARS_PER_ERA;
      yoe  = y - era * cdconv_pkg::YEARS_PER_ERA;
      mp   = (m > 2) ? m - 3 : m + 9;
      doy  = (153 * mp + 2) / 5 + d - 1;
      doe  = yoe * cdconv_pkg::DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
      days = era * cdconv_pkg::DAYS_PER_ERA + doe - cdconv_pkg::DAYS_TO_EPOCH;
      sod  = longint'(ts.hour) * cdconv_pkg::SECS_PER_HOUR
             + longint'(ts.minute) * cdconv_pkg::SECS_PER_MIN + longint'(ts.second);
    end
    days    = days + sod / cdconv_pkg::SECS_PER_DAY;
    sod     = sod % cdconv_pkg::SECS_PER_DAY;
    wrapped = days[cdconv_pkg::DC_W-1:0];
    days    = longint'(wrapped);

    z   = days + cdconv_pkg::DAYS_TO_EPOCH;
    era = (z >= 0 ? z : z - cdconv_pkg::LAST_ERA_DAY) / cdconv_pkg::DAYS_PER_ERA;
    doe = z - era * cdconv_pkg::DAYS_PER_ERA;
    yoe = (doe - doe / cdconv_pkg::QUAD_DAYS + doe / cdconv_pkg::CENT_DAYS
           - doe / cdconv_pkg::LAST_ERA_DAY) / cdconv_pkg::DAYS_PER_YEAR;
    doy = doe - (cdconv_pkg::DAYS_PER_YEAR * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * cdconv_pkg::YEARS_PER_ERA + ((m <= 2) ? 1 : 0);

    // Day zero of the count, 1970-01-01, was a Thursday.
    wd = days % 7;
    if (wd < 0) wd = wd + 7;
    wd = (wd + 4) % 7;

    res.day_count     = days[cdconv_pkg::DC_W-1:0];
    res.second_of_day = sod[cdconv_pkg::SOD_W-1:0];
    res.year          = y[cdconv_pkg::YR_W-1:0];
    res.month         = m[cdconv_pkg::MO_W-1:0];
    res.day           = d[cdconv_pkg::DY_W-1:0];
    res.weekday       = wd[cdconv_pkg::WD_W-1:0];
    res.hour          = cdconv_pkg::HR_W'(sod / cdconv_pkg::SECS_PER_HOUR);
    res.minute        = cdconv_pkg::MI_W'((sod % cdconv_pkg::SECS_PER_HOUR)
                                          / cdconv_pkg::SECS_PER_MIN);
    res.second        = cdconv_pkg::SC_W'(sod % cdconv_pkg::SECS_PER_MIN);
    return res;
  endfunction

  function automatic int idle_length(input bit no_gaps);
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic timestamp_t civil_stamp(input int y, input int mo, input int d,
                                             input int h, input int mi, input int s);
    timestamp_t ts;
    ts        = '0;
    ts.act    = cdconv_pkg::ACT_FROM_CIVIL;
    ts.year   = cdconv_pkg::YR_IN_W'(y);
    ts.month  = cdconv_pkg::MO_W'(mo);
    ts.day    = cdconv_pkg::DY_W'(d);
    ts.hour   = cdconv_pkg::HR_W'(h);
    ts.minute = cdconv_pkg::MI_W'(mi);
    ts.second = cdconv_pkg::SC_W'(s);
    return ts;
  endfunction

  function automatic timestamp_t count_stamp(input int dc, input int sod);
    timestamp_t ts;
    ts               = '0;
    ts.act           = cdconv_pkg::ACT_FROM_COUNT;
    ts.day_count     = cdconv_pkg::DC_W'(dc);
    ts.second_of_day = cdconv_pkg::SOD_W'(sod);
    return ts;
  endfunction

  function automatic timestamp_t random_stamp();
    timestamp_t ts;
    int pick;
    ts.act = cdconv_pkg::action_t'($urandom_range(0, 1));
    pick   = $urandom_range(0, 9);
    if (pick == 0) begin
      ts.day_count = cdconv_pkg::DC_W'(33554431 - int'($urandom_range(0, 400)));
    end else if (pick == 1) begin
      ts.day_count = cdconv_pkg::DC_W'(-33554432 + int'($urandom_range(0, 400)));
    end else if (pick < 5) begin
      ts.day_count = cdconv_pkg::DC_W'(int'($urandom_range(0, 1600000)) - 800000);
    end else begin
      ts.day_count = cdconv_pkg::DC_W'($urandom);
    end
    ts.second_of_day = ($urandom_range(0, 7) == 0) ? cdconv_pkg::SOD_W'($urandom)
                                                   : cdconv_pkg::SOD_W'($urandom_range(0, 86399));
    ts.year   = ($urandom_range(0, 2) == 0) ? cdconv_pkg::YR_IN_W'($urandom)
                                            : cdconv_pkg::YR_IN_W'($urandom_range(1600, 2400));
    ts.month  = ($urandom_range(0, 7) == 0) ? cdconv_pkg::MO_W'($urandom_range(0, 15))
                                            : cdconv_pkg::MO_W'($urandom_range(1, 12));
    ts.day    = ($urandom_range(0, 15) == 0) ? cdconv_pkg::DY_W'(0)
                                             : cdconv_pkg::DY_W'($urandom_range(1, 31));
    ts.hour   = ($urandom_range(0, 7) == 0) ? cdconv_pkg::HR_W'($urandom_range(0, 31))
                                            : cdconv_pkg::HR_W'($urandom_range(0, 23));
    ts.minute = ($urandom_range(0, 7) == 0) ? cdconv_pkg::MI_W'($urandom_range(0, 63))
                                            : cdconv_pkg::MI_W'($urandom_range(0, 59));
    ts.second = ($urandom_range(0, 7) == 0) ? cdconv_pkg::SC_W'($urandom_range(0, 63))
                                            : cdconv_pkg::SC_W'($urandom_range(0, 59));
    return ts;
  endfunction

  // Offers one timestamp and records its expected result once the transfer happens.
  task automatic send_timestamp(input timestamp_t ts);
    int gap;
    logic [cdconv_pkg::S_TDATA_W-1:0] word;
    gap = idle_length(steady_source);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[cdconv_pkg::IN_DC_LSB  +: cdconv_pkg::DC_W]    = ts.day_count;
    word[cdconv_pkg::IN_SOD_LSB +: cdconv_pkg::SOD_W]   = ts.second_of_day;
    word[cdconv_pkg::IN_YR_LSB  +: cdconv_pkg::YR_IN_W] = ts.year;
    word[cdconv_pkg::IN_MO_LSB  +: cdconv_pkg::MO_W]    = ts.month;
    word[cdconv_pkg::IN_DY_LSB  +: cdconv_pkg::DY_W]    = ts.day;
    word[cdconv_pkg::IN_HR_LSB  +: cdconv_pkg::HR_W]    = ts.hour;
    word[cdconv_pkg::IN_MI_LSB  +: cdconv_pkg::MI_W]    = ts.minute;
    word[cdconv_pkg::IN_SC_LSB  +: cdconv_pkg::SC_W]    = ts.second;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= ts.act;
    do @(posedge clk); while (!s_tready);
    expected_times.push_back(civil_convert(ts));
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_dates();
    send_timestamp(civil_stamp(1970, 1, 1, 0, 0, 0));
    send_timestamp(civil_stamp(2000, 2, 29, 23, 59, 59));
    send_timestamp(civil_stamp(-65536, 1, 1, 0, 0, 0));
    send_timestamp(civil_stamp(65535, 12, 31, 23, 59, 59));
    // Months outside the calendar range go through the offset formula unchanged.
    send_timestamp(civil_stamp(2023, 0, 15, 12, 0, 0));
    send_timestamp(civil_stamp(2023, 13, 1, 6, 30, 0));
    send_timestamp(civil_stamp(2023, 15, 31, 1, 2, 3));
    send_timestamp(civil_stamp(2024, 3, 0, 0, 0, 1));
    send_timestamp(civil_stamp(2023, 2, 31, 8, 8, 8));
    // Time fields at their widest carry a whole day into the count.
    send_timestamp(civil_stamp(1999, 12, 31, 31, 63, 63));
    send_timestamp(civil_stamp(0, 3, 1, 0, 0, 0));
    send_timestamp(civil_stamp(-1, 12, 31, 23, 59, 59));
    wait_until_drained();
  endtask

  task automatic test_directed_counts();
    send_timestamp(count_stamp(-33554432, 0));
    send_timestamp(count_stamp(33554431, 86399));
    // A carried day on the largest count wraps around to the most negative one.
    send_timestamp(count_stamp(33554431, 131071));
    send_timestamp(count_stamp(-1, 0));
    send_timestamp(count_stamp(0, 86400));
    send_timestamp(count_stamp(0, 131071));
    send_timestamp(count_stamp(-719468, 0));
    send_timestamp(count_stamp(-33554432, 86399));
    send_timestamp(count_stamp(19000, 43210));
    wait_until_drained();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    int n;
    hold_off      = 200;
    steady_source = 1'b1;
    for (n = 0; n < 40; n++) send_timestamp(random_stamp());
    steady_source = 1'b0;
    wait_until_drained();
  endtask

  task automatic test_random_mix();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = steady_source;
      end
      send_timestamp(random_stamp());
    end
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    wait_until_drained();
  endtask

  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        stall_left = idle_length(steady_sink);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.day_count     = m_tdata[cdconv_pkg::OUT_DC_LSB  +: cdconv_pkg::DC_W];
      got.second_of_day = m_tdata[cdconv_pkg::OUT_SOD_LSB +: cdconv_pkg::SOD_W];
      got.year          = m_tdata[cdconv_pkg::OUT_YR_LSB  +: cdconv_pkg::YR_W];
      got.month         = m_tdata[cdconv_pkg::OUT_MO_LSB  +: cdconv_pkg::MO_W];
      got.day           = m_tdata[cdconv_pkg::OUT_DY_LSB  +: cdconv_pkg::DY_W];
      got.weekday       = m_tdata[cdconv_pkg::OUT_WD_LSB  +: cdconv_pkg::WD_W];
      got.hour          = m_tdata[cdconv_pkg::OUT_HR_LSB  +: cdconv_pkg::HR_W];
      got.minute        = m_tdata[cdconv_pkg::OUT_MI_LSB  +: cdconv_pkg::MI_W];
      got.second        = m_tdata[cdconv_pkg::OUT_SC_LSB  +: cdconv_pkg::SC_W];
      if (expected_times.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected transfer: count %0d sod %0d date %0d-%0d-%0d",
                   got.day_count, got.second_of_day, got.year, got.month, got.day);
      end else begin
        want = expected_times.pop_front();
        diff = "";
        if (got.day_count !== want.day_count) diff = {diff, " day_count"};
        if (got.second_of_day !== want.second_of_day) diff = {diff, " second_of_day"};
        if (got.year !== want.year) diff = {diff, " year"};
        if (got.month !== want.month) diff = {diff, " month"};
        if (got.day !== want.day) diff = {diff, " day"};
        if (got.weekday !== want.weekday) diff = {diff, " weekday"};
        if (got.hour !== want.hour) diff = {diff, " hour"};
        if (got.minute !== want.minute) diff = {diff, " minute"};
        if (got.second !== want.second) diff = {diff, " second"};
        if (diff != "") begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch in%s: expected %0d %0d %0d-%0d-%0d wd %0d %0d:%0d:%0d", diff,
                     want.day_count, want.second_of_day, want.year, want.month, want.day,
                     want.weekday, want.hour, want.minute, want.second);
            $display("  got %0d %0d %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                     got.day_count, got.second_of_day, got.year, got.month, got.day,
                     got.weekday, got.hour, got.minute, got.second);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_dates();
    test_directed_counts();
    test_backpressure();
    test_random_mix();
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: civil_date_day_count_converter.f
+incdir+src
src/cdconv_pkg.sv
src/civil_date_day_count_converter.sv
src/cdconv_check.sv
bench/testbench.sv
